@@ rtl/rtpx_pkg.sv @@
// Shared types and constants for the RTP timestamp extender.
// No dependencies; imported by every module of the block.
package rtpx_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned EXT_W     = 2 * WORD_W;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic REG_STEP_WINDOW = 1'b0;

   localparam logic [WORD_W-1:0] STEP_WINDOW_RESET = 32'h1000_0000;

   typedef struct packed {
      logic [EXT_W-1:0] extended_time;
      logic [EXT_W-1:0] elapsed;
      logic             was_reset;
   } rtpx_result_type;

endpackage

@@ rtl/rtpx_csr.sv @@
// Configuration register file of the RTP timestamp extender (APB-style).
// Depends on rtpx_pkg.
module rtpx_csr import rtpx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [WORD_W-1:0]     step_window
);

   logic              reg_index;
   logic              wr_en;
   logic [WORD_W-1:0] window_ff;
   logic [WORD_W-1:0] window_in;

   assign reg_index = paddr[CSR_ADDR_W-1];
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      window_in = window_ff;
      unique case (reg_index)
         REG_STEP_WINDOW: if (wr_en) window_in = pwdata[WORD_W-1:0];
         default:         window_in = window_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= STEP_WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_STEP_WINDOW: prdata = window_ff;
         default:         prdata = '0;
      endcase
   end

   assign step_window = window_ff;

endmodule

@@ rtl/rtpx_core.sv @@
// Classification and extender state for the RTP timestamp extender.
// Depends on rtpx_pkg; updates state on each advanced request.
module rtpx_core import rtpx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [WORD_W-1:0] timestamp,
   input  logic              new_stream,
   input  logic [WORD_W-1:0] step_window,
   output rtpx_result_type   result
);

   logic [WORD_W-1:0] last_ff, last_in;
   logic [WORD_W-1:0] wrap_ff, wrap_in;
   logic [EXT_W-1:0]  base_ff, base_in;
   logic              started_ff, started_in;

   logic              same, ahead, fwd_ok, back_ok;
   logic [WORD_W-1:0] fwd, back;
   logic [WORD_W-1:0] cand_hi;
   logic [EXT_W-1:0]  cand_ext;
   logic              cand_fwd;   // forward step: no base check needed
   logic              force_rst;  // reset regardless of base
   logic              below_base;
   logic              do_rst;

   assign same    = (timestamp == last_ff);
   assign ahead   = (timestamp > last_ff);
   assign fwd     = timestamp - last_ff;
   assign back    = last_ff - timestamp;
   assign fwd_ok  = (fwd < step_window);
   assign back_ok = (back < step_window);

   always_comb begin
      cand_hi   = wrap_ff;
      cand_fwd  = 1'b1;
      force_rst = 1'b0;
      if (!started_ff || new_stream) begin
         force_rst = 1'b1;
      end else if (same) begin
         cand_hi = wrap_ff;
      end else if (fwd_ok) begin
         // forward step; crossing zero counts a wrap
         cand_hi = ahead ? wrap_ff : wrap_ff + WORD_W'(1);
      end else if (back_ok) begin
         cand_fwd = 1'b0;
         if (ahead) begin
            // backward across a wrap needs an earlier wrap period
            if (wrap_ff == '0) force_rst = 1'b1;
            cand_hi = wrap_ff - WORD_W'(1);
         end else begin
            cand_hi = wrap_ff;
         end
      end else begin
         force_rst = 1'b1;
      end
   end

   assign cand_ext   = {cand_hi, timestamp};
   assign below_base = (cand_ext < base_ff);
   assign do_rst     = force_rst || (!cand_fwd && below_base);

   always_comb begin
      last_in    = last_ff;
      wrap_in    = wrap_ff;
      base_in    = base_ff;
      started_in = started_ff;
      if (advance) begin
         if (do_rst) begin
            last_in    = timestamp;
            wrap_in    = '0;
            base_in    = {{WORD_W{1'b0}}, timestamp};
            started_in = 1'b1;
         end else if (cand_fwd) begin
            last_in = timestamp;
            wrap_in = cand_hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         wrap_ff    <= '0;
         base_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         last_ff    <= last_in;
         wrap_ff    <= wrap_in;
         base_ff    <= base_in;
         started_ff <= started_in;
      end
   end

   always_comb begin
      if (do_rst) begin
         result.extended_time = {{WORD_W{1'b0}}, timestamp};
         result.elapsed       = '0;
         result.was_reset     = 1'b1;
      end else begin
         result.extended_time = cand_ext;
         result.elapsed       = cand_ext - base_ff;
         result.was_reset     = 1'b0;
      end
   end

endmodule

@@ rtl/rtp_timestamp_extender.sv @@
// Top level of the RTP timestamp extender: request register, core, response register.
// Depends on rtpx_pkg, rtpx_csr and rtpx_core.
//
// Extends 32-bit RTP timestamps to 64 bits. Each request carries one stamp and
// a new_stream flag and yields exactly one response: the extended time (wrap
// count in the upper word, stamp in the lower word), the distance from the
// stream base, and was_reset. A request moves from the request register into the response
// register as soon as that register is free or drains, so a response stall can hold it
// there; with rsp_ready held high one request is accepted every cycle: the extender
// state (last stamp, wrap count, base) is read and rewritten between the request
// register and the response register, in the same cycle as the response is loaded,
// so each request sees the state its predecessor left. While the response side
// stalls the block holds two requests, one in each register, and then drops
// req_ready. Write step_window (byte address 0) only while no request is in
// flight; it resets to 0x10000000.
module rtp_timestamp_extender import rtpx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_W-1:0]     req_timestamp,
   input  logic                  req_new_stream,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [EXT_W-1:0]      rsp_extended_time,
   output logic [EXT_W-1:0]      rsp_elapsed,
   output logic                  rsp_was_reset,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [WORD_W-1:0] step_window;

   // request register
   logic              req_vld_ff, req_vld_in;
   logic [WORD_W-1:0] ts_ff, ts_in;
   logic              ns_ff, ns_in;

   // response register
   logic              rsp_vld_ff, rsp_vld_in;
   rtpx_result_type   rsp_ff, rsp_in;

   rtpx_result_type   core_result;
   logic              advance;
   logic              req_take;

   rtpx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .step_window (step_window)
   );

   // Advance the held request whenever the response register is free or drains.
   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   rtpx_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .timestamp   (ts_ff),
      .new_stream  (ns_ff),
      .step_window (step_window),
      .result      (core_result)
   );

   always_comb begin
      req_vld_in = req_vld_ff;
      ts_in      = ts_ff;
      ns_in      = ns_ff;
      if (req_take) begin
         // capture the new request
         req_vld_in = 1'b1;
         ts_in      = req_timestamp;
         ns_in      = req_new_stream;
      end else if (advance) begin
         req_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (advance) begin
         // load the finished result
         rsp_vld_in = 1'b1;
         rsp_in     = core_result;
      end else if (rsp_ready) begin
         // drop the delivered response
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload: hold without reset
   always_ff @(posedge clock) begin
      ts_ff  <= ts_in;
      ns_ff  <= ns_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_extended_time = rsp_ff.extended_time;
   assign rsp_elapsed       = rsp_ff.elapsed;
   assign rsp_was_reset     = rsp_ff.was_reset;

endmodule

@@ rtl/rtpx_checker.sv @@
// Port-level checks for the RTP timestamp extender, bound to the top level.
// Depends on rtpx_pkg and rtp_timestamp_extender.
module rtpx_checker import rtpx_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [EXT_W-1:0]      rsp_extended_time,
   input logic [EXT_W-1:0]      rsp_elapsed,
   input logic                  rsp_was_reset
);

   // A restart makes the stamp the base: zero wraps, zero elapsed.
   a_reset_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_reset |->
         rsp_elapsed == '0 && rsp_extended_time[EXT_W-1:WORD_W] == '0)
      else $error("restart response with nonzero elapsed or wrap word");

   // No response appears in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_extended_time)
         && $stable(rsp_elapsed) && $stable(rsp_was_reset))
      else $error("stalled response changed");

   // The request side never stalls while the response side is empty.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(reset) |-> req_ready)
      else $error("request stalled with empty response side");

endmodule

bind rtp_timestamp_extender rtpx_checker u_rtpx_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for rtp_timestamp_extender: directed table, then random stamp streams.
// Depends on rtpx_pkg and the rtp_timestamp_extender RTL; drives requests, checks every response.

module tb;
   import rtpx_pkg::*;

   localparam int unsigned LONG_HOLD = 200;   // receiver hold-off that backs up the pipeline
   localparam int unsigned SETTLE    = 8;     // cycles allowed after the last response
   localparam int unsigned PHASE_LEN = 400;   // random requests per window setting
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = {REG_STEP_WINDOW, 2'b00};

   // One directed request; the expected response is typed in only where known at sight
   typedef struct packed {
      logic [WORD_W-1:0] ts;
      logic              fresh;
      logic              typed;
      logic [EXT_W-1:0]  ext;
      logic [EXT_W-1:0]  span;
      logic              rst;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [WORD_W-1:0]     req_timestamp;
   logic                  req_new_stream;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [EXT_W-1:0]      rsp_extended_time;
   logic [EXT_W-1:0]      rsp_elapsed;
   logic                  rsp_was_reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Shadow of the extender state and its window register
   logic [WORD_W-1:0]     window_limit;
   logic [WORD_W-1:0]     last_seen;
   logic [WORD_W-1:0]     wraps;
   logic [EXT_W-1:0]      base_ext;
   logic                  stream_open;

   rtpx_result_type       pending_results[$];
   stim_row_type          directed_rows[$];
   int                    errors;
   int                    send_calm;
   int                    recv_calm;
   bit                    hold_off;

   rtp_timestamp_extender dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_timestamp     (req_timestamp),
      .req_new_stream    (req_new_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_extended_time (rsp_extended_time),
      .rsp_elapsed       (rsp_elapsed),
      .rsp_was_reset     (rsp_was_reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Extend one stamp against the shadow state and advance that state.
   // Forward reading wins over backward; any stamp that cannot be placed restarts the stream.
   function automatic rtpx_result_type extend_stamp(input logic [WORD_W-1:0] ts,
                                                    input logic fresh);
      rtpx_result_type   r;
      logic [WORD_W-1:0] fwd;
      logic [WORD_W-1:0] back;
      logic [WORD_W-1:0] prior_wraps;
      logic [EXT_W-1:0]  ext;
      logic              restart;
      fwd         = ts - last_seen;
      back        = last_seen - ts;
      prior_wraps = wraps - 1'b1;
      restart     = 1'b0;
      ext         = '0;
      if (!stream_open || fresh) begin
         restart = 1'b1;
      end else if (ts == last_seen) begin
         ext = {wraps, ts};
      end else if (ts > last_seen) begin
         if (fwd < window_limit) begin
            last_seen = ts;
            ext = {wraps, ts};
         end else if (back < window_limit) begin
            // backward across a wrap: needs a wrap to step back into
            if (wraps == '0) begin
               restart = 1'b1;
            end else begin
               ext = {prior_wraps, ts};
               if (ext < base_ext) restart = 1'b1;
            end
         end else begin
            restart = 1'b1;
         end
      end else begin
         if (fwd < window_limit) begin
            // forward across the 32-bit boundary
            wraps = wraps + 1'b1;
            last_seen = ts;
            ext = {wraps, ts};
         end else if (back < window_limit) begin
            ext = {wraps, ts};
            if (ext < base_ext) restart = 1'b1;
         end else begin
            restart = 1'b1;
         end
      end
      if (restart) begin
         base_ext    = {{WORD_W{1'b0}}, ts};
         last_seen   = ts;
         wraps       = '0;
         stream_open = 1'b1;
         ext         = base_ext;
      end
      r.extended_time = ext;
      r.elapsed       = ext - base_ext;
      r.was_reset     = restart;
      return r;
   endfunction

   // Draw a random idle gap per request, with occasional calm stretches of back-to-back traffic
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(31, 0) == 0) calm = $urandom_range(40, 10);
      return $urandom_range(3, 0);
   endfunction

   // Append one row to the directed table
   task automatic add_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Offer one request, hold it until accepted, then queue its expected response
   task automatic offer(input logic [WORD_W-1:0] ts, input logic fresh,
                        input logic typed, input rtpx_result_type known);
      rtpx_result_type pred;
      int              gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_timestamp  <= ts;
      req_new_stream <= fresh;
      do @(posedge clock); while (!req_ready);
      pred = extend_stamp(ts, fresh);
      pending_results.insert(pending_results.size(), typed ? known : pred);
      @(negedge clock);
   endtask

   // Wait until every response is back, then let the pipeline go quiet
   task automatic drain();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write step_window with the block idle, then read it back
   task automatic set_window(input logic [WORD_W-1:0] value);
      req_valid <= 1'b0;
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= WINDOW_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      window_limit = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value) begin
         $display("%0t: step_window readback expected %h actual %h", $time, value, prdata);
         errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Random stream under the current window: mostly plausible steps around the last stamp,
   // plus boundary hits, restarts and noise
   task automatic run_phase(input int count);
      logic [WORD_W-1:0] ts;
      logic [WORD_W-1:0] span;
      logic              fresh;
      int                pick;
      for (int i = 0; i < count; i++) begin
         span  = (window_limit > 1) ? window_limit - 1 : '0;
         fresh = 1'b0;
         pick  = $urandom_range(99, 0);
         if (pick < 55) begin
            ts = last_seen + $urandom_range(span, 0);
         end else if (pick < 70) begin
            ts = last_seen - $urandom_range(span, 0);
         end else if (pick < 75) begin
            ts = last_seen;
         end else if (pick < 80) begin
            case ($urandom_range(3, 0))
               0: ts = last_seen + window_limit;
               1: ts = last_seen + span;
               2: ts = last_seen - window_limit;
               default: ts = last_seen - span;
            endcase
         end else if (pick < 85) begin
            ts    = $urandom;
            fresh = 1'b1;
         end else begin
            ts    = $urandom;
            fresh = 1'($urandom_range(1, 0));
         end
         offer(ts, fresh, 1'b0, '0);
      end
   endtask

   // Response side: random ready stalls, one long hold-off on request, field-by-field check
   initial begin
      rtpx_result_type want;
      int              gap;
      rsp_ready = 1'b0;
      recv_calm = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = draw_gap(recv_calm);
         if (hold_off) begin
            hold_off = 1'b0;
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response ext %h elapsed %h was_reset %b", $time,
                     rsp_extended_time, rsp_elapsed, rsp_was_reset);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_extended_time !== want.extended_time) begin
               $display("%0t: extended_time expected %h actual %h", $time,
                        want.extended_time, rsp_extended_time);
               errors++;
            end
            if (rsp_elapsed !== want.elapsed) begin
               $display("%0t: elapsed expected %h actual %h", $time,
                        want.elapsed, rsp_elapsed);
               errors++;
            end
            if (rsp_was_reset !== want.was_reset) begin
               $display("%0t: was_reset expected %b actual %b", $time,
                        want.was_reset, rsp_was_reset);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   // Main sequence: reset, directed table, random phases over several windows, wind-down
   initial begin
      stim_row_type row;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_timestamp  = '0;
      req_new_stream = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      errors         = 0;
      send_calm      = 0;
      hold_off       = 1'b0;
      window_limit   = STEP_WINDOW_RESET;
      last_seen      = '0;
      wraps          = '0;
      base_ext       = '0;
      stream_open    = 1'b0;

      // Directed rows run under the reset window; typed rows restart or repeat a stamp
      // first stamp after reset restarts, then the same stamp repeats
      add_row('{32'hFFFF_FFF0, 1'b0, 1'b1, 64'hFFFF_FFF0, 64'h0, 1'b1});
      add_row('{32'hFFFF_FFF0, 1'b0, 1'b1, 64'hFFFF_FFF0, 64'h0, 1'b0});
      // forward wrap, backward step, backward across the wrap
      add_row('{32'h0000_0010, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      add_row('{32'h0000_0008, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      add_row('{32'hFFFF_FFF8, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      // backward across the wrap landing below the base
      add_row('{32'hFFFF_FFE0, 1'b0, 1'b1, 64'hFFFF_FFE0, 64'h0, 1'b1});
      // new stream, then backward across a wrap with no wrap counted yet
      add_row('{32'h0000_0010, 1'b1, 1'b1, 64'h0000_0010, 64'h0, 1'b1});
      add_row('{32'hFFFF_FFF0, 1'b0, 1'b1, 64'hFFFF_FFF0, 64'h0, 1'b1});
      // plain backward step below the base, then a forward step
      add_row('{32'hFFFF_FF00, 1'b0, 1'b1, 64'hFFFF_FF00, 64'h0, 1'b1});
      add_row('{32'hFFFF_FF01, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      // jump out of the window both ways, then new stream on the same stamp
      add_row('{32'h7FFF_FFFF, 1'b0, 1'b1, 64'h7FFF_FFFF, 64'h0, 1'b1});
      add_row('{32'h7FFF_FFFF, 1'b1, 1'b1, 64'h7FFF_FFFF, 64'h0, 1'b1});
      // stamp extremes: all ones, wrap by one to zero, back across
      add_row('{32'hFFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF, 64'h0, 1'b1});
      add_row('{32'h0000_0000, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      add_row('{32'hFFFF_FFFF, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      add_row('{32'h0000_0000, 1'b1, 1'b1, 64'h0, 64'h0, 1'b1});
      // steps of window minus one and of exactly the window
      add_row('{32'h0FFF_FFFF, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      add_row('{32'h1FFF_FFFF, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      add_row('{32'h1000_0000, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      add_row('{32'h9000_0000, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0});
      add_row('{32'hAAAA_AAAA, 1'b1, 1'b1, 64'hAAAA_AAAA, 64'h0, 1'b1});
      add_row('{32'h5555_5555, 1'b1, 1'b1, 64'h5555_5555, 64'h0, 1'b1});

      // hold reset, then release it at a falling edge
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         offer(row.ts, row.fresh, row.typed, '{row.ext, row.span, row.rst});
      end

      run_phase(PHASE_LEN);
      // smallest window: every differing stamp restarts
      set_window(32'h0000_0001);
      run_phase(PHASE_LEN);
      // widest window: wraps come fast
      set_window(32'h8000_0000);
      run_phase(PHASE_LEN);
      // random window; back up the pipeline with one long receiver hold-off
      set_window($urandom_range(32'h8000_0000, 1));
      hold_off = 1'b1;
      run_phase(PHASE_LEN);
      set_window(32'h0000_0100);
      run_phase(PHASE_LEN / 2);
      set_window(STEP_WINDOW_RESET);
      run_phase(PHASE_LEN / 2);

      // drop valid, wait out every response, then give the block time to misbehave
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rtpx_pkg.sv
rtl/rtpx_csr.sv
rtl/rtpx_core.sv
rtl/rtp_timestamp_extender.sv
rtl/rtpx_checker.sv
tb/sv/tb.sv
